// ===== rtl/core/scpa_pkg.sv =====
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, state type and control structures of the size class page
// allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int unsigned PageCount  = 8;
  localparam int unsigned PageBytes  = 256;
  localparam int unsigned ClassCount = 4;
  localparam int unsigned MinClassBytes = 16;

  localparam int unsigned SizeW     = 12;
  localparam int unsigned AddrW     = 11;
  localparam int unsigned PageIdxW  = $clog2(PageCount);
  localparam int unsigned PageShift = $clog2(PageBytes);
  localparam int unsigned ClassIdxW = (ClassCount > 1) ? $clog2(ClassCount) : 1;
  localparam int unsigned MinShift  = $clog2(MinClassBytes);
  localparam int unsigned OffsetW   = PageShift;
  localparam int unsigned BlocksW   = PageShift - MinShift + 1;
  localparam int unsigned RunW      = $clog2(PageCount + 1);
  localparam int unsigned NeedW     = SizeW - PageShift + 1;

  typedef enum logic [1:0] {
    StIdle,
    StClassify,
    StScan,
    StFinish
  } scpa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic commit;
  } scpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_scan;
    logic scan_last;
  } scpa_status_t;

endpackage

// ===== rtl/core/size_class_page_allocator.sv =====
// ----------------------------------------------------------------------------
// size_class_page_allocator
// Slab allocator over a pool of pages: small requests are served from
// power-of-two size classes, large ones take whole pages.
// ----------------------------------------------------------------------------
// The result strobe rises after the Classify and Finish states when a small
// request hits its class's current page or the size is zero; otherwise the
// page scan runs between them at one page per cycle over all eight pages.
// A new request is taken only while the allocator is idle (busy_o low).
// The result is shown for one cycle on result_valid_o and cannot be stalled.
// Reset is asynchronous and marks every page free with no current class pages.
module size_class_page_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [scpa_pkg::SizeW-1:0] request_size_i,
  output logic                       result_valid_o,
  output logic                       granted_o,
  output logic [scpa_pkg::AddrW-1:0] block_address_o
);

  scpa_pkg::scpa_cmd_t    cmd;
  scpa_pkg::scpa_status_t status;

  scpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  scpa_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .request_size_i  (request_size_i),
    .result_valid_o  (result_valid_o),
    .granted_o       (granted_o),
    .block_address_o (block_address_o)
  );

endmodule

// ===== rtl/core/scpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// scpa_ctrl
// Sequencer of the allocator: latches a request, runs the page scan when one
// is needed and commits the allocation.
// ----------------------------------------------------------------------------
module scpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  scpa_pkg::scpa_status_t status_i,
  output scpa_pkg::scpa_cmd_t    cmd_o
);

  scpa_pkg::scpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scpa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      scpa_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = scpa_pkg::StClassify;
        end
      end
      scpa_pkg::StClassify: begin
        cmd_o.scan_clear = 1'b1;
        if (status_i.no_scan) begin
          state_d = scpa_pkg::StFinish;
        end else begin
          state_d = scpa_pkg::StScan;
        end
      end
      scpa_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = scpa_pkg::StFinish;
        end
      end
      scpa_pkg::StFinish: begin
        cmd_o.commit = 1'b1;
        state_d      = scpa_pkg::StIdle;
      end
      default: begin
        state_d = scpa_pkg::StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/core/scpa_datapath.sv =====
// ----------------------------------------------------------------------------
// scpa_datapath
// Page map, per-class slab state, the page scan and the result register of
// the allocator.
// ----------------------------------------------------------------------------
module scpa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scpa_pkg::scpa_cmd_t            cmd_i,
  output scpa_pkg::scpa_status_t         status_o,
  input  logic [scpa_pkg::SizeW-1:0]    request_size_i,
  output logic                          result_valid_o,
  output logic                          granted_o,
  output logic [scpa_pkg::AddrW-1:0]    block_address_o
);

  localparam int unsigned PW = scpa_pkg::PageIdxW;
  localparam int unsigned CW = scpa_pkg::ClassIdxW;

  logic [scpa_pkg::SizeW-1:0]   size_q;
  logic [scpa_pkg::PageCount-1:0] free_map_q;
  logic [scpa_pkg::ClassCount-1:0] cls_valid_q;
  logic [PW-1:0]                   cls_page_q [scpa_pkg::ClassCount];
  logic [scpa_pkg::OffsetW-1:0]    cls_off_q  [scpa_pkg::ClassCount];
  logic [scpa_pkg::BlocksW-1:0]    cls_left_q [scpa_pkg::ClassCount];

  logic [PW-1:0]               scan_page_q;
  logic [scpa_pkg::RunW-1:0]   run_q;
  logic [PW-1:0]               start_q;
  logic                        found_q;

  logic                        res_valid_q;
  logic                        res_granted_q;
  logic [scpa_pkg::AddrW-1:0]  res_addr_q;

  // Request decode.
  logic                          is_zero, is_small, first_mode, small_hit;
  logic [CW-1:0]                 cls_idx;
  logic [scpa_pkg::OffsetW:0]    cls_bytes;
  logic [scpa_pkg::BlocksW-1:0]  cls_blocks;
  logic [scpa_pkg::SizeW:0]      size_round;
  logic [scpa_pkg::NeedW-1:0]    need;

  always_comb begin
    is_zero  = (size_q == '0);
    is_small = (size_q < scpa_pkg::SizeW'(scpa_pkg::PageBytes / 2));
    cls_idx  = '0;
    for (int k = scpa_pkg::ClassCount - 1; k >= 0; k--) begin
      if (size_q <= scpa_pkg::SizeW'(scpa_pkg::MinClassBytes << k)) begin
        cls_idx = CW'(k);
      end
    end
    cls_bytes  = (scpa_pkg::OffsetW + 1)'(scpa_pkg::MinClassBytes) << cls_idx;
    cls_blocks = scpa_pkg::BlocksW'(
                   (scpa_pkg::PageBytes >> scpa_pkg::MinShift) >> cls_idx);
    size_round = {1'b0, size_q} + (scpa_pkg::SizeW + 1)'(scpa_pkg::PageBytes - 1);
    need       = size_round[scpa_pkg::SizeW:scpa_pkg::PageShift];
    small_hit  = !is_zero && is_small && cls_valid_q[cls_idx];
    first_mode = is_small || (need == scpa_pkg::NeedW'(1));
  end

  assign status_o.no_scan   = is_zero || small_hit;
  assign status_o.scan_last = (scan_page_q == PW'(scpa_pkg::PageCount - 1));

  // One page of the scan per cycle.
  logic                       page_is_free;
  logic [scpa_pkg::RunW-1:0]  run_inc;
  logic [scpa_pkg::RunW:0]    run_start;

  always_comb begin
    page_is_free = free_map_q[scan_page_q];
    run_inc      = run_q + scpa_pkg::RunW'(1);
    run_start    = (scpa_pkg::RunW + 1)'(scan_page_q) + (scpa_pkg::RunW + 1)'(1)
                 - (scpa_pkg::RunW + 1)'(need);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_page_q <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan_clear) begin
      scan_page_q <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan_step) begin
      scan_page_q <= scan_page_q + PW'(1);
      if (page_is_free) begin
        run_q <= run_inc;
        if (first_mode) begin
          if (!found_q) begin
            found_q <= 1'b1;
          end
        end else if ({{(scpa_pkg::NeedW - scpa_pkg::RunW){1'b0}}, run_inc} == need) begin
          found_q <= 1'b1;
        end
      end else begin
        run_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q <= request_size_i;
    end
    if (cmd_i.scan_step && page_is_free) begin
      if (first_mode) begin
        if (!found_q) begin
          start_q <= scan_page_q;
        end
      end else if ({{(scpa_pkg::NeedW - scpa_pkg::RunW){1'b0}}, run_inc} == need) begin
        start_q <= run_start[PW-1:0];
      end
    end
  end

  // Pages taken by a large (whole-page) allocation.
  logic [scpa_pkg::PageCount-1:0] take_mask;
  always_comb begin
    for (int p = 0; p < scpa_pkg::PageCount; p++) begin
      take_mask[p] = ((PW + 1)'(p) >= {1'b0, start_q}) &&
                     ((scpa_pkg::NeedW + PW)'(p) <
                      (scpa_pkg::NeedW + PW)'(start_q) + (scpa_pkg::NeedW + PW)'(need));
    end
  end

  // Commit decision.
  logic                          ok;
  logic [PW-1:0]                 res_page;
  logic [scpa_pkg::OffsetW-1:0]  res_off;
  logic [scpa_pkg::BlocksW-1:0]  left_now, left_next;
  logic [scpa_pkg::OffsetW-1:0]  off_now;

  always_comb begin
    left_now  = small_hit ? cls_left_q[cls_idx] : cls_blocks;
    off_now   = small_hit ? cls_off_q[cls_idx] : '0;
    left_next = left_now - scpa_pkg::BlocksW'(1);
    res_page  = small_hit ? cls_page_q[cls_idx] : start_q;
    res_off   = off_now;
    if (is_zero) begin
      ok = 1'b0;
    end else if (small_hit) begin
      ok = 1'b1;
    end else begin
      ok = found_q;
    end
    if (!is_small) begin
      res_off = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q  <= '1;
      cls_valid_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.commit;
      if (cmd_i.commit && ok) begin
        if (is_small) begin
          cls_valid_q[cls_idx] <= (left_next != '0);
          if (!small_hit) begin
            free_map_q[start_q] <= 1'b0;
          end
        end else begin
          free_map_q <= free_map_q & ~take_mask;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_granted_q <= ok;
      res_addr_q    <= ok ? scpa_pkg::AddrW'({res_page, res_off}) : '0;
      if (ok && is_small) begin
        cls_page_q[cls_idx] <= res_page;
        cls_left_q[cls_idx] <= left_next;
        cls_off_q[cls_idx]  <= off_now + cls_bytes[scpa_pkg::OffsetW-1:0];
      end
    end
  end

  assign result_valid_o  = res_valid_q;
  assign granted_o       = res_granted_q;
  assign block_address_o = res_addr_q;

endmodule
